@@ hw/rtl/adbdf_pkg.sv @@
// Shared types and constants for the message deframer.
// Depends on nothing; used by the core, output register, top level and testbench.
`timescale 1ns / 1ps

package adbdf_pkg;

  localparam int HEADER_BYTES = 24;
  localparam int HDR_WORDS    = HEADER_BYTES / 4;
  localparam int POS_W        = $clog2(HEADER_BYTES);
  localparam int WIDX_W       = $clog2(HDR_WORDS);

  localparam int MAXLEN_W     = 21;
  localparam int CFG_DATA_W   = MAXLEN_W;
  localparam int CFG_IDX_W    = 2;

  localparam logic [31:0]         MAGIC_XOR     = 32'hffff_ffff;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET  = 21'd262144;

  localparam int W_COMMAND  = 0;
  localparam int W_ARG0     = 1;
  localparam int W_ARG1     = 2;
  localparam int W_LENGTH   = 3;
  localparam int W_CHECKSUM = 4;
  localparam int W_MAGIC    = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN  = 2'd0,
    CFG_CSUM_OFF = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_HEADER    = 3'd0,
    ST_PAYLOAD   = 3'd1,
    ST_OK        = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_BAD_SUM   = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] command;
    logic [31:0] arg_first;
    logic [31:0] arg_second;
    logic [31:0] length;
    logic [31:0] header_sum;
  } res_t;

endpackage

@@ hw/rtl/adbdf_in_if.sv @@
// Input channel: one received byte per item, valid/ready handshake.
// Stands alone; used by the top level.
`timescale 1ns / 1ps

interface adbdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/adbdf_out_if.sv @@
// Result channel: status, payload byte and header words per item.
// Stands alone; used by the top level.
`timescale 1ns / 1ps

interface adbdf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        last;
  logic [31:0] command;
  logic [31:0] arg_first;
  logic [31:0] arg_second;
  logic [31:0] length;
  logic [31:0] header_sum;

  modport source (output valid, output status, output payload_valid, output payload_byte,
                  output last, output command, output arg_first, output arg_second,
                  output length, output header_sum, input ready);
  modport sink   (input valid, input status, input payload_valid, input payload_byte,
                  input last, input command, input arg_first, input arg_second,
                  input length, input header_sum, output ready);
endinterface

@@ hw/rtl/adb_message_deframer.sv @@
// Deframer for a byte stream of 24-byte headers and payloads: one byte in, one
// result item out, one item per clock cycle unless the result channel stalls;
// the single update of header, count and sum state per accepted byte sets that
// rate, and each result appears in the cycle after its byte is accepted. The
// header words are checked for magic and length, payload bytes pass through
// with their byte sum; the last item of a message or error carries the header.
// Depends on adbdf_pkg, adbdf_in_if, adbdf_out_if, adbdf_core, adbdf_out_reg.
`timescale 1ns / 1ps

module adb_message_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  adbdf_in_if.sink                         in_ch,
  adbdf_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [adbdf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [adbdf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  adbdf_pkg::res_t res;
  adbdf_pkg::res_t out_res;
  logic            in_ready;
  logic            in_fire;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  adbdf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_ch.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  adbdf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .res       (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.status        = out_res.status;
  assign out_ch.payload_valid = out_res.payload_valid;
  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.last          = out_res.last;
  assign out_ch.command       = out_res.command;
  assign out_ch.arg_first     = out_res.arg_first;
  assign out_ch.arg_second    = out_res.arg_second;
  assign out_ch.length        = out_res.length;
  assign out_ch.header_sum    = out_res.header_sum;

endmodule

@@ hw/rtl/adbdf_core.sv @@
// Header assembly, checks, payload count and byte sum; holds the config registers.
// Depends on adbdf_pkg.
`timescale 1ns / 1ps

module adbdf_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  logic [7:0]                       rx_byte,
  input  logic                             cfg_we,
  input  logic [adbdf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [adbdf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output adbdf_pkg::res_t                  res
);

  logic [adbdf_pkg::MAXLEN_W-1:0] max_len_r;
  logic                           csum_off_r;

  logic [31:0]                    hdr_r   [adbdf_pkg::HDR_WORDS];
  logic [31:0]                    hdr_nxt [adbdf_pkg::HDR_WORDS];
  logic [adbdf_pkg::POS_W-1:0]    byte_pos_r, byte_pos_nxt;
  logic                           in_payload_r, in_payload_nxt;
  logic [31:0]                    bytes_left_r, bytes_left_nxt;
  logic [31:0]                    run_sum_r, run_sum_nxt;

  logic [adbdf_pkg::POS_W-1:0]    pos;
  logic [adbdf_pkg::WIDX_W-1:0]   widx;
  logic [31:0]                    sum_new;
  logic [31:0]                    left_new;
  logic [31:0]                    magic_new;
  logic                           fin;

  always_comb begin
    hdr_nxt        = hdr_r;
    byte_pos_nxt   = byte_pos_r;
    in_payload_nxt = in_payload_r;
    bytes_left_nxt = bytes_left_r;
    run_sum_nxt    = run_sum_r;
    fin            = 1'b0;
    res            = '0;
    res.status     = adbdf_pkg::ST_HEADER;

    pos = (byte_pos_r >= adbdf_pkg::POS_W'(adbdf_pkg::HEADER_BYTES)) ? '0 : byte_pos_r;
    widx = pos[adbdf_pkg::POS_W-1:2];
    sum_new   = run_sum_r + {24'd0, rx_byte};
    left_new  = bytes_left_r - 32'd1;
    magic_new = {rx_byte, hdr_r[adbdf_pkg::W_MAGIC][23:0]};

    if (in_payload_r) begin
      res.payload_valid = 1'b1;
      res.payload_byte  = rx_byte;
      run_sum_nxt       = sum_new;
      bytes_left_nxt    = left_new;
      if (left_new == 32'd0) begin
        fin = 1'b1;
        if (csum_off_r || sum_new == hdr_r[adbdf_pkg::W_CHECKSUM]) begin
          res.status = adbdf_pkg::ST_OK;
        end else begin
          res.status = adbdf_pkg::ST_BAD_SUM;
        end
      end else begin
        res.status = adbdf_pkg::ST_PAYLOAD;
      end
    end else begin
      hdr_nxt[widx][pos[1:0]*8 +: 8] = rx_byte;
      if (pos != adbdf_pkg::POS_W'(adbdf_pkg::HEADER_BYTES - 1)) begin
        byte_pos_nxt = pos + adbdf_pkg::POS_W'(1);
      end else if (magic_new != (hdr_r[adbdf_pkg::W_COMMAND] ^ adbdf_pkg::MAGIC_XOR)) begin
        fin        = 1'b1;
        res.status = adbdf_pkg::ST_BAD_MAGIC;
      end else if (hdr_r[adbdf_pkg::W_LENGTH] == 32'd0) begin
        fin        = 1'b1;
        res.status = adbdf_pkg::ST_OK;
      end else if (hdr_r[adbdf_pkg::W_LENGTH] > {11'd0, max_len_r}) begin
        fin        = 1'b1;
        res.status = adbdf_pkg::ST_TOO_LONG;
      end else begin
        byte_pos_nxt   = '0;
        in_payload_nxt = 1'b1;
        bytes_left_nxt = hdr_r[adbdf_pkg::W_LENGTH];
        run_sum_nxt    = '0;
      end
    end

    if (fin) begin
      byte_pos_nxt   = '0;
      in_payload_nxt = 1'b0;
      bytes_left_nxt = '0;
      run_sum_nxt    = '0;
      res.last       = 1'b1;
      res.command    = hdr_r[adbdf_pkg::W_COMMAND];
      res.arg_first  = hdr_r[adbdf_pkg::W_ARG0];
      res.arg_second = hdr_r[adbdf_pkg::W_ARG1];
      res.length     = hdr_r[adbdf_pkg::W_LENGTH];
      res.header_sum = hdr_r[adbdf_pkg::W_CHECKSUM];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= adbdf_pkg::MAXLEN_RESET;
      csum_off_r   <= 1'b0;
      byte_pos_r   <= '0;
      in_payload_r <= 1'b0;
      bytes_left_r <= '0;
      run_sum_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          adbdf_pkg::CFG_MAX_LEN:  max_len_r  <= cfg_wdata;
          adbdf_pkg::CFG_CSUM_OFF: csum_off_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        byte_pos_r   <= byte_pos_nxt;
        in_payload_r <= in_payload_nxt;
        bytes_left_r <= bytes_left_nxt;
        run_sum_r    <= run_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

@@ hw/rtl/adbdf_out_reg.sv @@
// Result register between the deframing logic and the result channel.
// Depends on adbdf_pkg.
`timescale 1ns / 1ps

module adbdf_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  adbdf_pkg::res_t res,
  output logic            out_valid,
  input  logic            out_ready,
  output adbdf_pkg::res_t out_res
);

  logic            valid_r;
  adbdf_pkg::res_t res_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res;
    end
  end

endmodule

@@ verif/adb_message_deframer_checker.sv @@
// Checker for the message deframer: watches both channels and the register port,
// predicts each result item and compares it field by field with what arrives.
// Depends on adbdf_pkg, adbdf_in_if and adbdf_out_if.
`timescale 1ns / 1ps

module adb_message_deframer_checker
  import adbdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  adbdf_in_if                   in_ch,
  adbdf_out_if                  out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    n_ok,
  output int                    n_bad_magic,
  output int                    n_too_long,
  output int                    n_bad_sum
);

  logic [31:0]         hdr_words [HDR_WORDS];
  logic [4:0]          hdr_pos;
  bit                  in_body;
  logic [31:0]         body_left;
  logic [31:0]         body_total;
  logic [MAXLEN_W-1:0] max_len;
  bit                  sum_off;

  res_t exp_q [$];
  int   err_total;

  task automatic restart_hunt();
    hdr_pos    = '0;
    in_body    = 1'b0;
    body_left  = '0;
    body_total = '0;
  endtask

  // Advance the deframing state by one byte and work out the item it causes.
  task automatic deframe_byte(input logic [7:0] b, output res_t r);
    int widx;
    int sh;
    r = '0;
    r.status = ST_HEADER;
    if (in_body) begin
      body_total = body_total + b;
      body_left  = body_left - 1;
      r.payload_valid = 1'b1;
      r.payload_byte  = b;
      if (body_left == 0) begin
        r.status = (sum_off || body_total == hdr_words[W_CHECKSUM]) ? ST_OK : ST_BAD_SUM;
        r.last   = 1'b1;
        restart_hunt();
      end else begin
        r.status = ST_PAYLOAD;
      end
    end else begin
      widx = hdr_pos >> 2;
      sh   = hdr_pos[1:0] * 8;
      hdr_words[widx][sh +: 8] = b;
      if (hdr_pos + 1 < HEADER_BYTES) begin
        hdr_pos = hdr_pos + 1;
      end else if (hdr_words[W_MAGIC] != (hdr_words[W_COMMAND] ^ MAGIC_XOR)) begin
        r.status = ST_BAD_MAGIC;
        r.last   = 1'b1;
        restart_hunt();
      end else if (hdr_words[W_LENGTH] == 0) begin
        r.status = ST_OK;
        r.last   = 1'b1;
        restart_hunt();
      end else if (hdr_words[W_LENGTH] > {11'd0, max_len}) begin
        r.status = ST_TOO_LONG;
        r.last   = 1'b1;
        restart_hunt();
      end else begin
        hdr_pos    = '0;
        in_body    = 1'b1;
        body_left  = hdr_words[W_LENGTH];
        body_total = '0;
      end
    end
    if (r.last) begin
      r.command    = hdr_words[W_COMMAND];
      r.arg_first  = hdr_words[W_ARG0];
      r.arg_second = hdr_words[W_ARG1];
      r.length     = hdr_words[W_LENGTH];
      r.header_sum = hdr_words[W_CHECKSUM];
    end
  endtask

  function automatic bit same_result(res_t e, res_t a);
    return e.status === a.status && e.payload_valid === a.payload_valid &&
           e.payload_byte === a.payload_byte && e.last === a.last &&
           e.command === a.command && e.arg_first === a.arg_first &&
           e.arg_second === a.arg_second && e.length === a.length &&
           e.header_sum === a.header_sum;
  endfunction

  task automatic show_item(input string tag, input res_t r);
    $display("  %s st=%0d pv=%0d pb=%02h last=%0d cmd=%08h a0=%08h a1=%08h len=%08h sum=%08h",
             tag, r.status, r.payload_valid, r.payload_byte, r.last, r.command,
             r.arg_first, r.arg_second, r.length, r.header_sum);
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      for (int i = 0; i < HDR_WORDS; i++) hdr_words[i] = '0;
      restart_hunt();
      max_len   = MAXLEN_RESET;
      sum_off   = 1'b0;
      exp_q.delete();
      err_total = 0;
      fail_count  <= 0;
      pending     <= 0;
      n_ok        <= 0;
      n_bad_magic <= 0;
      n_too_long  <= 0;
      n_bad_sum   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status        = status_t'(out_ch.status);
        got.payload_valid = out_ch.payload_valid;
        got.payload_byte  = out_ch.payload_byte;
        got.last          = out_ch.last;
        got.command       = out_ch.command;
        got.arg_first     = out_ch.arg_first;
        got.arg_second    = out_ch.arg_second;
        got.length        = out_ch.length;
        got.header_sum    = out_ch.header_sum;
        if (exp_q.size() == 0) begin
          if (err_total < 10) begin
            $display("%0t: result item with nothing expected", $time);
            show_item("got", got);
          end
          err_total++;
        end else begin
          want = exp_q.pop_front();
          if (!same_result(want, got)) begin
            if (err_total < 10) begin
              $display("%0t: result item mismatch", $time);
              show_item("exp", want);
              show_item("got", got);
            end
            err_total++;
          end
          if (want.last) begin
            case (want.status)
              ST_OK:        n_ok        <= n_ok + 1;
              ST_BAD_MAGIC: n_bad_magic <= n_bad_magic + 1;
              ST_TOO_LONG:  n_too_long  <= n_too_long + 1;
              ST_BAD_SUM:   n_bad_sum   <= n_bad_sum + 1;
              default: ;
            endcase
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAX_LEN:  max_len = cfg_wdata[MAXLEN_W-1:0];
          CFG_CSUM_OFF: sum_off = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.rx_byte, want);
        exp_q.push_back(want);
      end
      pending    <= exp_q.size();
      fail_count <= err_total;
    end
  end

endmodule

@@ verif/adb_message_deframer_test.sv @@
// Testbench top for the message deframer: clock, reset, framed byte stimulus
// with bursty input and stalling output, register phases and the verdict.
// Depends on adbdf_pkg, both channel interfaces, the block and its checker.
`timescale 1ns / 1ps

module adb_message_deframer_test;
  import adbdf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BYTES   = 150;

  typedef enum {SUM_GOOD, SUM_FLIP, SUM_RANDOM} sum_kind_t;
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  adbdf_in_if  in_ch ();
  adbdf_out_if out_ch ();

  int fail_count;
  int pending;
  int n_ok;
  int n_bad_magic;
  int n_too_long;
  int n_bad_sum;

  int                  n_sent;
  int                  burst_left;
  logic [MAXLEN_W-1:0] cur_max;

  adb_message_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  adb_message_deframer_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_ok        (n_ok),
    .n_bad_magic (n_bad_magic),
    .n_too_long  (n_too_long),
    .n_bad_sum   (n_bad_sum)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("timeout with %0d result items outstanding", pending);
    $display("adb_message_deframer_test: errors");
    $finish;
  end

  // Receiver: the stall pattern changes from span to span, chosen among four modes.
  initial begin
    int mode;
    int span;
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (hold > 0) begin
              hold--;
              out_ch.ready <= 1'b0;
            end else begin
              out_ch.ready <= 1'b1;
              if ($urandom_range(0, 7) == 0) hold = $urandom_range(5, 30);
            end
          end
        endcase
      end
    end
  end

  // Offer one byte, in bursts with idle gaps between them; hold until taken.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 64);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    n_sent++;
  endtask

  // Drop valid and wait until every expected item has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_LEN) cur_max = data[MAXLEN_W-1:0];
  endtask

  // Send one header and, where the header lets a payload through, its payload.
  task automatic send_frame(input logic [31:0] cmd, arg_a, arg_b, len, magic,
                            input sum_kind_t sk, input fill_t fk);
    logic [31:0] words [HDR_WORDS];
    logic [7:0]  body [$];
    logic [31:0] total;
    logic [7:0]  b;
    int          n;
    int          i;
    total = '0;
    n = (magic == ~cmd && len != 0 && len <= {11'd0, cur_max}) ? int'(len) : 0;
    for (i = 0; i < n; i++) begin
      case (fk)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hff;
        default:   b = 8'($urandom);
      endcase
      body.push_back(b);
      total = total + b;
    end
    words[W_COMMAND] = cmd;
    words[W_ARG0]    = arg_a;
    words[W_ARG1]    = arg_b;
    words[W_LENGTH]  = len;
    words[W_MAGIC]   = magic;
    case (sk)
      SUM_GOOD: words[W_CHECKSUM] = total;
      SUM_FLIP: words[W_CHECKSUM] = total ^ (32'h1 << $urandom_range(0, 31));
      default:  words[W_CHECKSUM] = $urandom;
    endcase
    for (i = 0; i < HEADER_BYTES; i++) put_byte(words[i / 4][(i % 4) * 8 +: 8]);
    for (i = 0; i < n; i++) put_byte(body[i]);
  endtask

  task automatic random_frame();
    logic [31:0] cmd;
    logic [31:0] len;
    logic [31:0] magic;
    sum_kind_t   sk;
    int          r;
    cmd = $urandom;
    r   = $urandom_range(0, 99);
    if (r < 4) begin
      // pure noise header
      send_frame(cmd, $urandom, $urandom, $urandom, $urandom, SUM_RANDOM, FILL_RANDOM);
    end else begin
      magic = (r < 10) ? (~cmd ^ (32'h1 << $urandom_range(0, 31))) : ~cmd;
      r = $urandom_range(0, 99);
      if (r < 10)      len = 0;
      else if (r < 75) len = $urandom_range(1, 16);
      else if (r < 82) len = (cur_max <= 48) ? {11'd0, cur_max} : $urandom_range(17, 48);
      else if (r < 92) len = {11'd0, cur_max} + 1 + $urandom_range(0, 1000);
      else if (r < 96) len = 32'h8000_0000 | $urandom;
      else             len = 32'hffff_ffff;
      r = $urandom_range(0, 99);
      sk = (r < 85) ? SUM_GOOD : (r < 95) ? SUM_FLIP : SUM_RANDOM;
      send_frame(cmd, $urandom, $urandom, len, magic, sk, FILL_RANDOM);
    end
  endtask

  initial begin
    int ph;
    int stop_at;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_MAX_LEN;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    cur_max    = MAXLEN_RESET;
    n_sent     = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero length, extremes, bad magic, sums, too long
    send_frame(32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);
    send_frame(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, SUM_RANDOM,
               FILL_RANDOM);
    send_frame(32'h1234_5678, $urandom, $urandom, 32'h0, 32'h1234_5678, SUM_GOOD, FILL_RANDOM);
    send_frame(32'h0f0f_0f0f, $urandom, $urandom, 32'hffff_ffff, 32'h0f0f_0f0f, SUM_GOOD,
               FILL_RANDOM);
    send_frame(32'h4e584e43, $urandom, $urandom, 32'd1, ~32'h4e584e43, SUM_GOOD, FILL_RANDOM);
    send_frame(32'h4e584e43, $urandom, $urandom, 32'd3, ~32'h4e584e43, SUM_FLIP, FILL_RANDOM);
    send_frame($urandom, $urandom, $urandom, 32'd4, 32'h0, SUM_GOOD, FILL_ONES);
    send_frame(32'hffff_ffff, $urandom, $urandom, 32'd4, 32'h0, SUM_GOOD, FILL_ONES);
    send_frame(32'h0, $urandom, $urandom, 32'd4, 32'hffff_ffff, SUM_GOOD, FILL_ZERO);
    send_frame(32'h0, $urandom, $urandom, 32'd262145, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);
    send_frame(32'h0, $urandom, $urandom, 32'h8000_0000, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);
    send_frame(32'h0, $urandom, $urandom, 32'hffff_ffff, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);

    // length exactly at and just over the limit; spare indexes must be ignored
    write_reg(CFG_MAX_LEN, 21'd5);
    send_frame(32'h5, $urandom, $urandom, 32'd5, ~32'h5, SUM_GOOD, FILL_RANDOM);
    send_frame(32'h6, $urandom, $urandom, 32'd6, ~32'h6, SUM_GOOD, FILL_RANDOM);
    write_reg(CFG_SPARE_A, 21'd0);
    write_reg(CFG_SPARE_B, 21'h1fffff);
    send_frame(32'h7, $urandom, $urandom, 32'd5, ~32'h7, SUM_GOOD, FILL_RANDOM);

    // checksum bypass: upper data bits carry no meaning
    write_reg(CFG_CSUM_OFF, 21'h1ffffe);
    send_frame($urandom, $urandom, $urandom, 32'd2, 32'h0, SUM_FLIP, FILL_RANDOM);
    write_reg(CFG_CSUM_OFF, 21'h1fffff);
    send_frame(32'h0, $urandom, $urandom, 32'd2, 32'hffff_ffff, SUM_FLIP, FILL_RANDOM);
    send_frame(32'h0, $urandom, $urandom, 32'd5, 32'hffff_ffff, SUM_RANDOM, FILL_RANDOM);

    write_reg(CFG_MAX_LEN, 21'd0);
    send_frame(32'h0, $urandom, $urandom, 32'd1, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);
    send_frame(32'h0, $urandom, $urandom, 32'd0, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);

    write_reg(CFG_MAX_LEN, 21'h1fffff);
    send_frame(32'h0, $urandom, $urandom, 32'h0020_0000, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);
    send_frame(32'h0, $urandom, $urandom, 32'd7, 32'hffff_ffff, SUM_FLIP, FILL_RANDOM);

    write_reg(CFG_CSUM_OFF, 21'd0);
    write_reg(CFG_MAX_LEN, 21'd1048576);
    send_frame(32'h0, $urandom, $urandom, 32'd1048577, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);
    send_frame(32'h0, $urandom, $urandom, 32'd9, 32'hffff_ffff, SUM_GOOD, FILL_RANDOM);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_reg(CFG_MAX_LEN, CFG_DATA_W'($urandom_range(0, 40)));
        1: write_reg(CFG_MAX_LEN, 21'd1048576);
        2: write_reg(CFG_MAX_LEN, 21'h1fffff);
        3: write_reg(CFG_MAX_LEN, 21'd0);
        4: write_reg(CFG_MAX_LEN, CFG_DATA_W'($urandom));
        default: write_reg(CFG_MAX_LEN, MAXLEN_RESET);
      endcase
      write_reg(CFG_CSUM_OFF, CFG_DATA_W'($urandom));
      stop_at = n_sent + PHASE_BYTES;
      while (n_sent < stop_at) random_frame();
    end

    settle();
    repeat (4) @(posedge clk);
    $display("run: %0d bytes over %0d register phases", n_sent, RANDOM_PHASES + 5);
    $display("ends seen: %0d ok, %0d bad magic, %0d too long, %0d bad sum, %0d failures",
             n_ok, n_bad_magic, n_too_long, n_bad_sum, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("adb_message_deframer_test: clean");
    end else begin
      $display("adb_message_deframer_test: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/adbdf_pkg.sv
hw/rtl/adbdf_in_if.sv
hw/rtl/adbdf_out_if.sv
hw/rtl/adbdf_core.sv
hw/rtl/adbdf_out_reg.sv
hw/rtl/adb_message_deframer.sv
verif/adb_message_deframer_checker.sv
verif/adb_message_deframer_test.sv
